### rtl/core/epipolar_homography_inlier_filter_top_macros.svh
// assertion macros for the inlier filter
// no dependencies; included by the top level
`ifndef EPIPOLAR_HOMOGRAPHY_INLIER_FILTER_TOP_MACROS_SVH
`define EPIPOLAR_HOMOGRAPHY_INLIER_FILTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// checked outside reset
`define EHIF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("inlier filter assertion failed");
// checked during reset too
`define EHIF_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("inlier filter assertion failed");
`else
`define EHIF_ASSERT(lbl, clk, rst, prop)
`define EHIF_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### rtl/core/ehif_pkg.sv
// shared types, constants and helpers of the inlier filter
// no dependencies
package ehif_pkg;

   localparam int CoordWidth    = 24;
   localparam int IndexWidth    = 16;
   localparam int EntryWidth    = 32;
   localparam int LimitWidth    = 32;
   localparam int ModeWidth     = 2;
   localparam int CsrDataWidth  = 64;
   localparam int CsrIndexWidth = 3;
   localparam int NumEntries    = 9;

   // geometry modes; the unused code acts as bypass
   localparam logic [ModeWidth-1:0] MODE_BYPASS     = 2'd0;
   localparam logic [ModeWidth-1:0] MODE_EPIPOLAR   = 2'd1;
   localparam logic [ModeWidth-1:0] MODE_HOMOGRAPHY = 2'd2;
   localparam logic [ModeWidth-1:0] MODE_UNUSED     = 2'd3;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] REG_MODE      = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_LIMIT     = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_ENTRY_0_1 = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_ENTRY_2_3 = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_ENTRY_4_5 = 3'd4;
   localparam logic [CsrIndexWidth-1:0] REG_ENTRY_6_7 = 3'd5;
   localparam logic [CsrIndexWidth-1:0] REG_ENTRY_8   = 3'd6;

   localparam logic [LimitWidth-1:0] LIMIT_RESET = 32'd262144;

   typedef struct packed {
      logic signed [CoordWidth-1:0] first_x;
      logic signed [CoordWidth-1:0] first_y;
      logic signed [CoordWidth-1:0] second_x;
      logic signed [CoordWidth-1:0] second_y;
      logic [IndexWidth-1:0]        first_index;
      logic [IndexWidth-1:0]        second_index;
   } req_payload_type;

   typedef struct packed {
      logic                  keep;
      logic [IndexWidth-1:0] kept_first_index;
      logic [IndexWidth-1:0] kept_second_index;
   } rsp_payload_type;

   typedef struct packed {
      logic [ModeWidth-1:0]                   mode;
      logic [LimitWidth-1:0]                  limit;
      logic [NumEntries-1:0][EntryWidth-1:0]  entry;
   } cfg_type;

   // square from partial products lo*lo, lo*hi, hi*hi with a 32-bit split
   function automatic logic [127:0] sq_combine(input logic [63:0] ll,
                                               input logic [63:0] lh,
                                               input logic [63:0] hh);
      sq_combine = {64'd0, ll} + ({64'd0, lh} << 33) + {hh, 64'd0};
   endfunction

endpackage

### rtl/core/ehif_req_if.sv
// request channel of the inlier filter
// depends on ehif_pkg
interface ehif_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [ehif_pkg::CoordWidth-1:0] first_x;
   logic signed [ehif_pkg::CoordWidth-1:0] first_y;
   logic signed [ehif_pkg::CoordWidth-1:0] second_x;
   logic signed [ehif_pkg::CoordWidth-1:0] second_y;
   logic [ehif_pkg::IndexWidth-1:0]        first_index;
   logic [ehif_pkg::IndexWidth-1:0]        second_index;

   modport source(output valid, first_x, first_y, second_x, second_y, first_index,
                  second_index, input ready);
   modport sink(input valid, first_x, first_y, second_x, second_y, first_index,
                second_index, output ready);
endinterface

### rtl/core/ehif_rsp_if.sv
// result channel of the inlier filter
// depends on ehif_pkg
interface ehif_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            keep;
   logic [ehif_pkg::IndexWidth-1:0] kept_first_index;
   logic [ehif_pkg::IndexWidth-1:0] kept_second_index;

   modport source(output valid, keep, kept_first_index, kept_second_index, input ready);
   modport sink(input valid, keep, kept_first_index, kept_second_index, output ready);
endinterface

### rtl/core/ehif_datapath.sv
// eight-stage arithmetic pipeline of the inlier filter
// depends on ehif_pkg
module ehif_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  ehif_pkg::req_payload_type in_data,
   input  ehif_pkg::cfg_type         cfg,
   output logic                      out_valid,
   output ehif_pkg::rsp_payload_type out_data
);

   localparam int Stages = 8;

   typedef struct packed {
      logic [ehif_pkg::IndexWidth-1:0] first;
      logic [ehif_pkg::IndexWidth-1:0] second;
   } idx_type;

   logic                 valid_ff [Stages];
   idx_type              idx_ff   [Stages];
   logic signed [31:0]   entry_s  [9];

   // stage 1: matrix entry times coordinate
   logic signed [55:0] prod_in [10];
   logic signed [55:0] prod_ff [10];
   logic signed [23:0] x2_ff1, y2_ff1;

   // stage 2: floored row products
   logic signed [57:0] sum_a [3];
   logic signed [57:0] sum_b [2];
   logic signed [39:0] a_in [3];
   logic signed [39:0] b_in [2];
   logic signed [39:0] a_ff [3];
   logic signed [39:0] b_ff [2];
   logic signed [23:0] x2_ff2, y2_ff2;

   // stage 3: coordinate products and square partials
   logic signed [39:0] sqv   [5];
   logic [39:0]        mag3  [5];
   logic [63:0]        ll3_in [5];
   logic [39:0]        lh3_in [5];
   logic [15:0]        hh3_in [5];
   logic [63:0]        ll3_ff [5];
   logic [39:0]        lh3_ff [5];
   logic [15:0]        hh3_ff [5];
   logic signed [63:0] xa0_in, ya1_in, xa2_in, ya2_in;
   logic signed [63:0] xa0_ff, ya1_ff, xa2_ff, ya2_ff;
   logic signed [39:0] a3_ff [3];
   logic               dz_in, hz_in;
   logic               dz_ff3, hz_ff3;

   // stage 4: residuals and squares
   logic signed [63:0] e_in, r0_in, r1_in;
   logic signed [63:0] e_ff, r0_ff, r1_ff;
   logic [79:0]        sq4_in [5];
   logic [79:0]        sq4_ff [5];
   logic               dz_ff4, hz_ff4;

   // stage 5: denominator and residual square partials
   logic [79:0]        d_in, d_ff, h2sq_ff5;
   logic signed [63:0] rv [3];
   logic [63:0]        mag5 [3];
   logic [63:0]        ll5_in [3], lh5_in [3], hh5_in [3];
   logic [63:0]        ll5_ff [3], lh5_ff [3], hh5_ff [3];
   logic               dz_ff5, hz_ff5;

   // stage 6: residual squares and limit partials
   logic [127:0]       rsq6_in [3];
   logic [127:0]       rsq6_ff [3];
   logic [63:0]        dp0_in, dp1_in, hp0_in, hp1_in;
   logic [47:0]        dp2_in, hp2_in;
   logic [63:0]        dp0_ff, dp1_ff, hp0_ff, hp1_ff;
   logic [47:0]        dp2_ff, hp2_ff;
   logic               dz_ff6, hz_ff6;

   // stage 7: both sides of the tests
   logic [127:0]       rsum_in, rsum_ff, e2_ff7;
   logic [111:0]       dlim_in, hlim_in, dlim_ff, hlim_ff;
   logic               dz_ff7, hz_ff7;

   // stage 8: decision
   logic               keep_in, keep_ff;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         entry_s[i] = $signed(cfg.entry[i]);
      end
   end

   // valid and index shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Stages; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < Stages; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         idx_ff[0] <= '{first: in_data.first_index, second: in_data.second_index};
         for (int k = 1; k < Stages; k++) idx_ff[k] <= idx_ff[k-1];
      end
   end

   // stage 1 products
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         prod_in[r]   = entry_s[3*r] * in_data.first_x;
         prod_in[r+3] = entry_s[3*r+1] * in_data.first_y;
      end
      for (int c = 0; c < 2; c++) begin
         prod_in[c+6] = entry_s[c] * in_data.second_x;
         prod_in[c+8] = entry_s[c+3] * in_data.second_y;
      end
   end

   // stage 2 sums, floored by 2^18
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum_a[r] = 58'(prod_ff[r]) + 58'(prod_ff[r+3]) + (58'(entry_s[3*r+2]) <<< 8);
         a_in[r]  = sum_a[r][57:18];
      end
      for (int c = 0; c < 2; c++) begin
         sum_b[c] = 58'(prod_ff[c+6]) + 58'(prod_ff[c+8]) + (58'(entry_s[c+6]) <<< 8);
         b_in[c]  = sum_b[c][57:18];
      end
   end

   // stage 3 products and square partials
   always_comb begin
      sqv[0] = a_ff[0];
      sqv[1] = a_ff[1];
      sqv[2] = a_ff[2];
      sqv[3] = b_ff[0];
      sqv[4] = b_ff[1];
      for (int k = 0; k < 5; k++) begin
         mag3[k]   = sqv[k][39] ? 40'(-sqv[k]) : 40'(sqv[k]);
         ll3_in[k] = 64'(mag3[k][31:0]) * 64'(mag3[k][31:0]);
         lh3_in[k] = 40'(mag3[k][31:0]) * 40'(mag3[k][39:32]);
         hh3_in[k] = 16'(mag3[k][39:32]) * 16'(mag3[k][39:32]);
      end
      xa0_in = x2_ff2 * a_ff[0];
      ya1_in = y2_ff2 * a_ff[1];
      xa2_in = x2_ff2 * a_ff[2];
      ya2_in = y2_ff2 * a_ff[2];
      dz_in  = (a_ff[0] == '0) && (a_ff[1] == '0) && (b_ff[0] == '0) && (b_ff[1] == '0);
      hz_in  = (a_ff[2] == '0);
   end

   // stage 4 residuals and squares
   always_comb begin
      e_in  = xa0_ff + ya1_ff + (64'(a3_ff[2]) <<< 8);
      r0_in = (64'(a3_ff[0]) <<< 8) - xa2_ff;
      r1_in = (64'(a3_ff[1]) <<< 8) - ya2_ff;
      for (int k = 0; k < 5; k++) begin
         sq4_in[k] = 80'(ehif_pkg::sq_combine(ll3_ff[k], 64'(lh3_ff[k]), 64'(hh3_ff[k])));
      end
   end

   // stage 5 denominator and residual partials
   always_comb begin
      d_in  = sq4_ff[0] + sq4_ff[1] + sq4_ff[3] + sq4_ff[4];
      rv[0] = e_ff;
      rv[1] = r0_ff;
      rv[2] = r1_ff;
      for (int k = 0; k < 3; k++) begin
         mag5[k]   = rv[k][63] ? 64'(-rv[k]) : 64'(rv[k]);
         ll5_in[k] = 64'(mag5[k][31:0]) * 64'(mag5[k][31:0]);
         lh5_in[k] = 64'(mag5[k][31:0]) * 64'(mag5[k][63:32]);
         hh5_in[k] = 64'(mag5[k][63:32]) * 64'(mag5[k][63:32]);
      end
   end

   // stage 6 residual squares and limit partials
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rsq6_in[k] = ehif_pkg::sq_combine(ll5_ff[k], lh5_ff[k], hh5_ff[k]);
      end
      dp0_in = 64'(d_ff[31:0]) * 64'(cfg.limit);
      dp1_in = 64'(d_ff[63:32]) * 64'(cfg.limit);
      dp2_in = 48'(d_ff[79:64]) * 48'(cfg.limit);
      hp0_in = 64'(h2sq_ff5[31:0]) * 64'(cfg.limit);
      hp1_in = 64'(h2sq_ff5[63:32]) * 64'(cfg.limit);
      hp2_in = 48'(h2sq_ff5[79:64]) * 48'(cfg.limit);
   end

   // stage 7 sums
   always_comb begin
      rsum_in = rsq6_ff[1] + rsq6_ff[2];
      dlim_in = 112'(dp0_ff) + (112'(dp1_ff) << 32) + (112'(dp2_ff) << 64);
      hlim_in = 112'(hp0_ff) + (112'(hp1_ff) << 32) + (112'(hp2_ff) << 64);
   end

   // stage 8 decision
   always_comb begin
      priority if (cfg.mode == ehif_pkg::MODE_EPIPOLAR) begin
         keep_in = !dz_ff7 && (e2_ff7 <= 128'(dlim_ff));
      end else if (cfg.mode == ehif_pkg::MODE_HOMOGRAPHY) begin
         keep_in = !hz_ff7 && (rsum_ff <= 128'(hlim_ff));
      end else begin
         keep_in = 1'b1;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         x2_ff1  <= in_data.second_x;
         y2_ff1  <= in_data.second_y;

         a_ff   <= a_in;
         b_ff   <= b_in;
         x2_ff2 <= x2_ff1;
         y2_ff2 <= y2_ff1;

         ll3_ff <= ll3_in;
         lh3_ff <= lh3_in;
         hh3_ff <= hh3_in;
         xa0_ff <= xa0_in;
         ya1_ff <= ya1_in;
         xa2_ff <= xa2_in;
         ya2_ff <= ya2_in;
         a3_ff  <= a_ff;
         dz_ff3 <= dz_in;
         hz_ff3 <= hz_in;

         e_ff   <= e_in;
         r0_ff  <= r0_in;
         r1_ff  <= r1_in;
         sq4_ff <= sq4_in;
         dz_ff4 <= dz_ff3;
         hz_ff4 <= hz_ff3;

         d_ff     <= d_in;
         h2sq_ff5 <= sq4_ff[2];
         ll5_ff   <= ll5_in;
         lh5_ff   <= lh5_in;
         hh5_ff   <= hh5_in;
         dz_ff5   <= dz_ff4;
         hz_ff5   <= hz_ff4;

         rsq6_ff <= rsq6_in;
         dp0_ff  <= dp0_in;
         dp1_ff  <= dp1_in;
         dp2_ff  <= dp2_in;
         hp0_ff  <= hp0_in;
         hp1_ff  <= hp1_in;
         hp2_ff  <= hp2_in;
         dz_ff6  <= dz_ff5;
         hz_ff6  <= hz_ff5;

         rsum_ff <= rsum_in;
         e2_ff7  <= rsq6_ff[0];
         dlim_ff <= dlim_in;
         hlim_ff <= hlim_in;
         dz_ff7  <= dz_ff6;
         hz_ff7  <= hz_ff6;

         keep_ff <= keep_in;
      end
   end

   assign out_valid                  = valid_ff[Stages-1];
   assign out_data.keep              = keep_ff;
   assign out_data.kept_first_index  = idx_ff[Stages-1].first;
   assign out_data.kept_second_index = idx_ff[Stages-1].second;

endmodule

### rtl/core/epipolar_homography_inlier_filter_top.sv
// Geometric inlier filter for candidate point matches. One request enters per clock while
// the pipeline is not stalled; the rate is one match per cycle, set by the eight-stage
// multiplier pipeline, which advances whenever the result register is empty or being
// taken. A held result stalls the whole pipeline. The user must write configuration
// registers through the csr_ port only while no request is in flight; not enforced here.
// depends on ehif_pkg, ehif_req_if, ehif_rsp_if, ehif_datapath and the macros header
`include "epipolar_homography_inlier_filter_top_macros.svh"

module epipolar_homography_inlier_filter_top (
   input  logic                                  clock,
   input  logic                                  reset,
   ehif_req_if.sink                              req_if,
   ehif_rsp_if.source                            rsp_if,
   input  logic                                  csr_we,
   input  logic [ehif_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [ehif_pkg::CsrDataWidth-1:0]     csr_wdata
);

   logic [ehif_pkg::ModeWidth-1:0]  mode_ff;
   logic [ehif_pkg::LimitWidth-1:0] limit_ff;
   logic [ehif_pkg::NumEntries-1:0][ehif_pkg::EntryWidth-1:0] entry_ff;
   ehif_pkg::cfg_type               cfg;
   ehif_pkg::req_payload_type       req_data;
   ehif_pkg::rsp_payload_type       rsp_data;
   logic                            en;
   logic                            out_valid;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ehif_pkg::MODE_BYPASS;
         limit_ff <= ehif_pkg::LIMIT_RESET;
         entry_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ehif_pkg::REG_MODE:      mode_ff  <= csr_wdata[1:0];
            ehif_pkg::REG_LIMIT:     limit_ff <= csr_wdata[31:0];
            ehif_pkg::REG_ENTRY_0_1: begin
               entry_ff[0] <= csr_wdata[31:0];
               entry_ff[1] <= csr_wdata[63:32];
            end
            ehif_pkg::REG_ENTRY_2_3: begin
               entry_ff[2] <= csr_wdata[31:0];
               entry_ff[3] <= csr_wdata[63:32];
            end
            ehif_pkg::REG_ENTRY_4_5: begin
               entry_ff[4] <= csr_wdata[31:0];
               entry_ff[5] <= csr_wdata[63:32];
            end
            ehif_pkg::REG_ENTRY_6_7: begin
               entry_ff[6] <= csr_wdata[31:0];
               entry_ff[7] <= csr_wdata[63:32];
            end
            ehif_pkg::REG_ENTRY_8:   entry_ff[8] <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   assign cfg.mode  = mode_ff;
   assign cfg.limit = limit_ff;
   assign cfg.entry = entry_ff;

   // pipeline moves unless a result is held
   assign en           = !(out_valid && !rsp_if.ready);
   assign req_if.ready = en;

   assign req_data.first_x      = req_if.first_x;
   assign req_data.first_y      = req_if.first_y;
   assign req_data.second_x     = req_if.second_x;
   assign req_data.second_y     = req_if.second_y;
   assign req_data.first_index  = req_if.first_index;
   assign req_data.second_index = req_if.second_index;

   ehif_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_if.valid),
      .in_data  (req_data),
      .cfg      (cfg),
      .out_valid(out_valid),
      .out_data (rsp_data)
   );

   assign rsp_if.valid             = out_valid;
   assign rsp_if.keep              = rsp_data.keep;
   assign rsp_if.kept_first_index  = rsp_data.kept_first_index;
   assign rsp_if.kept_second_index = rsp_data.kept_second_index;

   // checks
   `EHIF_ASSERT(a_ready_only_on_stall, clock, reset, !req_if.ready |-> (rsp_if.valid && !rsp_if.ready))
   `EHIF_ASSERT(a_bypass_keeps, clock, reset, (rsp_if.valid && (mode_ff == ehif_pkg::MODE_BYPASS)) |-> rsp_if.keep)
   `EHIF_ASSERT_ALWAYS(a_reset_empties, clock, $past(reset) |-> !rsp_if.valid)

endmodule
